// ----- src/nsc_pkg.sv -----
// Shared types, character constants, code values and lookup functions for the
// NMEA sentence checker. No dependencies.
package nsc_pkg;

   localparam int unsigned ADDR_DEPTH = 5;
   localparam logic [2:0] ADDR_MAX = 3'd5;
   localparam logic [2:0] TALKER_LEN = 3'd2;

   localparam logic [7:0] CH_DOLLAR = 8'h24;
   localparam logic [7:0] CH_STAR   = 8'h2A;
   localparam logic [7:0] CH_COMMA  = 8'h2C;
   localparam logic [7:0] CH_CR     = 8'h0D;
   localparam logic [7:0] CH_LF     = 8'h0A;

   localparam logic [2:0] ERR_NONE     = 3'd0;
   localparam logic [2:0] ERR_DOLLAR   = 3'd1;
   localparam logic [2:0] ERR_STAR     = 3'd2;
   localparam logic [2:0] ERR_HEX      = 3'd3;
   localparam logic [2:0] ERR_CHECKSUM = 3'd4;
   localparam logic [2:0] ERR_ENDING   = 3'd5;

   localparam logic [2:0] TALKER_UNKNOWN = 3'd0;
   localparam logic [2:0] TALKER_GP      = 3'd1;
   localparam logic [2:0] TALKER_GL      = 3'd2;
   localparam logic [2:0] TALKER_GA      = 3'd3;
   localparam logic [2:0] TALKER_GB      = 3'd4;
   localparam logic [2:0] TALKER_GQ      = 3'd5;
   localparam logic [2:0] TALKER_GN      = 3'd6;

   localparam logic [3:0] SENT_UNKNOWN = 4'd0;
   localparam logic [3:0] SENT_GBS     = 4'd1;
   localparam logic [3:0] SENT_GGA     = 4'd2;
   localparam logic [3:0] SENT_GLL     = 4'd3;
   localparam logic [3:0] SENT_GNS     = 4'd4;
   localparam logic [3:0] SENT_GSA     = 4'd5;
   localparam logic [3:0] SENT_GST     = 4'd6;
   localparam logic [3:0] SENT_GSV     = 4'd7;
   localparam logic [3:0] SENT_RMC     = 4'd8;
   localparam logic [3:0] SENT_VTG     = 4'd9;
   localparam logic [3:0] SENT_ZDA     = 4'd10;

   typedef enum logic [2:0] {
      PH_DOLLAR = 3'd0,
      PH_BODY   = 3'd1,
      PH_HEX1   = 3'd2,
      PH_HEX2   = 3'd3,
      PH_CR     = 3'd4,
      PH_LF     = 3'd5,
      PH_DONE   = 3'd6,
      PH_FAULT  = 3'd7
   } phase_type;

   typedef logic [ADDR_DEPTH-1:0][7:0] addr_chars_type;

   typedef struct packed {
      logic       sentence_ok;
      logic [2:0] error_code;
      logic [2:0] talker_code;
      logic [3:0] sentence_code;
      logic [7:0] computed_xor;
   } result_type;

   // Bit 4 set means the character is not an upper-case hex digit.
   function automatic logic [4:0] hex_decode(input logic [7:0] c);
      logic [4:0] v;
      if (c >= 8'h30 && c <= 8'h39) begin
         v = {1'b0, 4'(c - 8'h30)};
      end else if (c >= 8'h41 && c <= 8'h46) begin
         v = {1'b0, 4'(c - 8'h37)};
      end else begin
         v = 5'h10;
      end
      return v;
   endfunction

   function automatic logic [2:0] talker_lookup(input logic [15:0] pair);
      logic [2:0] code;
      unique case (pair)
         "GP":    code = TALKER_GP;
         "GL":    code = TALKER_GL;
         "GA":    code = TALKER_GA;
         "GB":    code = TALKER_GB;
         "GQ":    code = TALKER_GQ;
         "GN":    code = TALKER_GN;
         default: code = TALKER_UNKNOWN;
      endcase
      return code;
   endfunction

   function automatic logic [3:0] sentence_lookup(input logic [23:0] tri_chars);
      logic [3:0] code;
      unique case (tri_chars)
         "GBS":   code = SENT_GBS;
         "GGA":   code = SENT_GGA;
         "GLL":   code = SENT_GLL;
         "GNS":   code = SENT_GNS;
         "GSA":   code = SENT_GSA;
         "GST":   code = SENT_GST;
         "GSV":   code = SENT_GSV;
         "RMC":   code = SENT_RMC;
         "VTG":   code = SENT_VTG;
         "ZDA":   code = SENT_ZDA;
         default: code = SENT_UNKNOWN;
      endcase
      return code;
   endfunction

endpackage

// ----- src/nmea_sentence_checker_unit.sv -----
// NMEA 0183 sentence checker, top level: input register, parser, result register.
// A word accepted into the input register is parsed from there; a result is loaded
//   into the result register (rsp_tvalid) when its last word (tlast) is parsed.
// Throughput: one word per cycle, except while a held last word waits for a full result register.
// Reset (synchronous, active high) empties both registers and returns the
//   parser to waiting for a leading '$'. Depends on nsc_pkg and nsc_parser.
module nmea_sentence_checker_unit (
   input  logic        clock,
   input  logic        reset,
   // Character stream in.
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [7:0]  req_tdata,   // [7:0] char_byte
   input  logic        req_tlast,   // end_of_string
   // One result word per sentence.
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [23:0] rsp_tdata,   // [2:0] error_code, [5:3] talker_code,
                                    // [9:6] sentence_code, [17:10] computed_xor,
                                    // [23:18] zero
   output logic [0:0]  rsp_tuser    // [0] sentence_ok
);

   logic                in_valid_ff;
   logic [7:0]          in_char_ff;
   logic                in_eos_ff;
   logic                advance;
   logic                out_valid_ff;
   nsc_pkg::result_type out_ff;
   nsc_pkg::result_type result;

   // Advance the held word unless it ends a sentence and the result slot is full and not being read.
   assign advance    = in_valid_ff && (!in_eos_ff || !out_valid_ff || rsp_tready);
   assign req_tready = !in_valid_ff || advance;

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (req_tready) begin
         in_valid_ff <= req_tvalid;
      end
   end

   always_ff @(posedge clock) begin
      if (req_tready) begin
         in_char_ff <= req_tdata;
         in_eos_ff  <= req_tlast;
      end
   end

   nsc_parser u_parser (
      .clock      (clock),
      .reset      (reset),
      .item_valid (advance),
      .item_char  (in_char_ff),
      .item_eos   (in_eos_ff),
      .result     (result)
   );

   // Result register: load on the last char, drop once the consumer takes it.
   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else if (advance && in_eos_ff) begin
         out_valid_ff <= 1'b1;
      end else if (rsp_tready) begin
         out_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (advance && in_eos_ff) begin
         out_ff <= result;
      end
   end

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tuser  = out_ff.sentence_ok;
   assign rsp_tdata  = {6'b000000, out_ff.computed_xor, out_ff.sentence_code,
                        out_ff.talker_code, out_ff.error_code};

endmodule

// ----- src/nsc_classify.sv -----
// Address field classifier: talker and sentence type from the captured chars.
// Depends on nsc_pkg.
module nsc_classify (
   input  nsc_pkg::addr_chars_type addr_chars,
   input  logic [2:0]              addr_count,
   output logic [2:0]              talker_code,
   output logic [3:0]              sentence_code
);

   always_comb begin
      // Entries at or above the count are never looked at.
      if (addr_count < nsc_pkg::TALKER_LEN) begin
         talker_code = nsc_pkg::TALKER_UNKNOWN;
      end else begin
         talker_code = nsc_pkg::talker_lookup({addr_chars[0], addr_chars[1]});
      end
      if (addr_count < nsc_pkg::ADDR_MAX) begin
         sentence_code = nsc_pkg::SENT_UNKNOWN;
      end else begin
         sentence_code = nsc_pkg::sentence_lookup({addr_chars[2], addr_chars[3],
                                                   addr_chars[4]});
      end
   end

endmodule

// ----- src/nsc_parser.sv -----
// Sentence framing state, running checksum and address capture.
// Depends on nsc_pkg and nsc_classify.
module nsc_parser (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 item_valid,
   input  logic [7:0]           item_char,
   input  logic                 item_eos,
   output nsc_pkg::result_type  result
);

   nsc_pkg::phase_type      phase_ff, phase_in;
   logic [7:0]              xor_ff, xor_in;
   logic [3:0]              nibble_ff, nibble_in;
   logic [2:0]              err_ff, err_in;
   logic [2:0]              count_ff, count_in;
   logic                    done_ff, done_in;
   nsc_pkg::addr_chars_type chars_ff, chars_in;
   logic [2:0]              final_err;
   logic [4:0]              hex;
   logic [2:0]              talker_code;
   logic [3:0]              sentence_code;

   always_comb begin
      phase_in  = phase_ff;
      xor_in    = xor_ff;
      nibble_in = nibble_ff;
      err_in    = err_ff;
      count_in  = count_ff;
      done_in   = done_ff;
      chars_in  = chars_ff;
      hex       = nsc_pkg::hex_decode(item_char);

      // Capture the address field: up to five chars after the first char, ending at ',' or '*'.
      if (phase_ff != nsc_pkg::PH_DOLLAR && !done_ff) begin
         if (item_char == nsc_pkg::CH_COMMA || item_char == nsc_pkg::CH_STAR) begin
            done_in = 1'b1;
         end else if (count_ff < nsc_pkg::ADDR_MAX) begin
            chars_in[count_ff] = item_char;
            count_in = count_ff + 3'd1;
         end
      end

      unique case (phase_ff)
         nsc_pkg::PH_DOLLAR: begin
            if (item_char == nsc_pkg::CH_DOLLAR) begin
               phase_in = nsc_pkg::PH_BODY;
            end else begin
               err_in   = nsc_pkg::ERR_DOLLAR;
               phase_in = nsc_pkg::PH_FAULT;
            end
         end
         nsc_pkg::PH_BODY: begin
            if (item_char == nsc_pkg::CH_STAR) begin
               phase_in = nsc_pkg::PH_HEX1;
            end else begin
               xor_in = xor_ff ^ item_char;
            end
         end
         nsc_pkg::PH_HEX1: begin
            if (hex[4]) begin
               err_in   = nsc_pkg::ERR_HEX;
               phase_in = nsc_pkg::PH_FAULT;
            end else begin
               nibble_in = hex[3:0];
               phase_in  = nsc_pkg::PH_HEX2;
            end
         end
         nsc_pkg::PH_HEX2: begin
            if (hex[4]) begin
               err_in   = nsc_pkg::ERR_HEX;
               phase_in = nsc_pkg::PH_FAULT;
            end else if ({nibble_ff, hex[3:0]} != xor_ff) begin
               err_in   = nsc_pkg::ERR_CHECKSUM;
               phase_in = nsc_pkg::PH_FAULT;
            end else begin
               phase_in = nsc_pkg::PH_CR;
            end
         end
         nsc_pkg::PH_CR: begin
            if (item_char == nsc_pkg::CH_CR) begin
               phase_in = nsc_pkg::PH_LF;
            end else begin
               err_in   = nsc_pkg::ERR_ENDING;
               phase_in = nsc_pkg::PH_FAULT;
            end
         end
         nsc_pkg::PH_LF: begin
            if (item_char == nsc_pkg::CH_LF) begin
               phase_in = nsc_pkg::PH_DONE;
            end else begin
               err_in   = nsc_pkg::ERR_ENDING;
               phase_in = nsc_pkg::PH_FAULT;
            end
         end
         nsc_pkg::PH_DONE: begin
            // Anything after LF spoils the ending.
            err_in   = nsc_pkg::ERR_ENDING;
            phase_in = nsc_pkg::PH_FAULT;
         end
         nsc_pkg::PH_FAULT: begin
            // Hold: the first error sticks until the end of the sentence.
         end
      endcase

      // Sentence cut short: name the error by where it stopped.
      final_err = err_in;
      if (err_in == nsc_pkg::ERR_NONE) begin
         priority case (phase_in)
            nsc_pkg::PH_BODY:                   final_err = nsc_pkg::ERR_STAR;
            nsc_pkg::PH_HEX1, nsc_pkg::PH_HEX2: final_err = nsc_pkg::ERR_HEX;
            nsc_pkg::PH_CR, nsc_pkg::PH_LF:     final_err = nsc_pkg::ERR_ENDING;
            default:                            final_err = err_in;
         endcase
      end

      result.sentence_ok   = (final_err == nsc_pkg::ERR_NONE);
      result.error_code    = final_err;
      result.talker_code   = talker_code;
      result.sentence_code = sentence_code;
      result.computed_xor  = xor_in;
   end

   nsc_classify u_classify (
      .addr_chars    (chars_in),
      .addr_count    (count_in),
      .talker_code   (talker_code),
      .sentence_code (sentence_code)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff  <= nsc_pkg::PH_DOLLAR;
         xor_ff    <= 8'h00;
         nibble_ff <= 4'h0;
         err_ff    <= nsc_pkg::ERR_NONE;
         count_ff  <= 3'd0;
         done_ff   <= 1'b0;
      end else if (item_valid) begin
         if (item_eos) begin
            phase_ff  <= nsc_pkg::PH_DOLLAR;
            xor_ff    <= 8'h00;
            nibble_ff <= 4'h0;
            err_ff    <= nsc_pkg::ERR_NONE;
            count_ff  <= 3'd0;
            done_ff   <= 1'b0;
         end else begin
            phase_ff  <= phase_in;
            xor_ff    <= xor_in;
            nibble_ff <= nibble_in;
            err_ff    <= err_in;
            count_ff  <= count_in;
            done_ff   <= done_in;
         end
      end
   end

   // Address chars are only read below the fill count, so they need no reset.
   always_ff @(posedge clock) begin
      if (item_valid) begin
         chars_ff <= chars_in;
      end
   end

endmodule

// ----- src/nsc_checker.sv -----
// Port-level assertions for the NMEA sentence checker, bound to the top level.
// Depends on nsc_pkg and nmea_sentence_checker_unit.
module nsc_checker (
   input logic        clock,
   input logic        reset,
   input logic        rsp_tvalid,
   input logic        rsp_tready,
   input logic [23:0] rsp_tdata,
   input logic [0:0]  rsp_tuser
);

   // A result never shows up the cycle after reset.
   a_reset_empty: assert property (@(posedge clock) reset |=> !rsp_tvalid)
      else $error("result valid right after reset");

   // A stalled result word holds.
   a_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tuser))
      else $error("stalled result changed");

   // The ok flag agrees with the error code.
   a_ok_flag: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> (rsp_tuser[0] == (rsp_tdata[2:0] == nsc_pkg::ERR_NONE)))
      else $error("sentence_ok disagrees with error_code");

   // Codes stay within their defined ranges and padding stays zero.
   a_ranges: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> (rsp_tdata[2:0] <= nsc_pkg::ERR_ENDING) &&
                     (rsp_tdata[5:3] <= nsc_pkg::TALKER_GN) &&
                     (rsp_tdata[9:6] <= nsc_pkg::SENT_ZDA) && (rsp_tdata[23:18] == 6'd0))
      else $error("result code out of range");

endmodule

bind nmea_sentence_checker_unit nsc_checker u_nsc_checker (
   .clock      (clock),
   .reset      (reset),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata),
   .rsp_tuser  (rsp_tuser)
);

// ----- verif/nmea_sentence_checker_unit_test.sv -----
// Self-checking testbench for nmea_sentence_checker_unit: directed sentences, then random
// sentences, some well formed and some broken, checked against a cycle-free model of the parser.
// Depends on nsc_pkg and the checker RTL only.
`timescale 1ns / 1ps

module nmea_sentence_checker_unit_test;

   localparam logic [7:0] CH_ZERO    = "0";
   localparam logic [7:0] CH_NINE    = "9";
   localparam logic [7:0] CH_UPPER_A = "A";
   localparam logic [7:0] CH_UPPER_F = "F";
   localparam logic [7:0] CH_UPPER_Z = "Z";
   localparam logic [7:0] CH_LOWER_A = "a";
   localparam logic [7:0] CH_SPACE   = " ";
   localparam logic [7:0] CH_TILDE   = "~";

   // Talker and sentence names, indexed by their result code.
   localparam logic [15:0] TALKER_NAMES [1:6] = '{"GP", "GL", "GA", "GB", "GQ", "GN"};
   localparam logic [23:0] SENT_NAMES [1:10] =
      '{"GBS", "GGA", "GLL", "GNS", "GSA", "GST", "GSV", "RMC", "VTG", "ZDA"};

   localparam int RANDOM_WORDS     = 610;
   localparam int RANDOM_SENTENCES = 30;

   typedef struct {
      logic [7:0]          ch;
      bit                  last;
      bit                  typed;   // use want instead of the predicted verdict
      nsc_pkg::result_type want;
   } stim_row_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [7:0]  req_tdata = '0;    // [7:0] char_byte
   logic        req_tlast = 1'b0;  // end_of_string
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [23:0] rsp_tdata;         // [2:0] error_code, [5:3] talker_code,
                                   // [9:6] sentence_code, [17:10] computed_xor
   logic [0:0]  rsp_tuser;         // [0] sentence_ok

   nmea_sentence_checker_unit dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tlast  (req_tlast),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser)
   );

   // Parser model state.
   nsc_pkg::phase_type ph;
   logic [7:0]         xor_acc;
   logic [3:0]         hi_nib;
   logic [2:0]         err;
   logic [2:0]         addr_len;
   logic               addr_closed;
   logic [7:0]         addr_buf [nsc_pkg::ADDR_DEPTH];

   nsc_pkg::result_type expected_verdicts [$];
   stim_row_type        directed_rows [$];
   logic [7:0]          sentence_buf [$];
   int                  mismatch_count = 0;
   int                  source_run = 0;
   int                  sink_run = 0;

   initial begin
      forever #1 clock = ~clock;
   end

   initial begin
      #400_000;
      $display("nmea_sentence_checker_unit_test: done, errors");
      $finish;
   end

   // ---------------------------------------------------------------- model

   task automatic clear_checker();
      ph = nsc_pkg::PH_DOLLAR;
      xor_acc = '0;
      hi_nib = '0;
      err = nsc_pkg::ERR_NONE;
      addr_len = '0;
      addr_closed = 1'b0;
      for (int k = 0; k < nsc_pkg::ADDR_DEPTH; k++) addr_buf[k] = '0;
   endtask

   // Bit 4 flags a character that is not an upper-case hex digit.
   function automatic logic [4:0] hex_nibble(input logic [7:0] c);
      if (c >= CH_ZERO && c <= CH_NINE) return {1'b0, 4'(c - CH_ZERO)};
      if (c >= CH_UPPER_A && c <= CH_UPPER_F) return {1'b0, 4'(c - CH_UPPER_A + 8'd10)};
      return 5'h10;
   endfunction

   function automatic logic [2:0] talker_of();
      logic [2:0] code;
      code = nsc_pkg::TALKER_UNKNOWN;
      if (addr_len >= nsc_pkg::TALKER_LEN)
         for (int k = 1; k <= 6; k++)
            if ({addr_buf[0], addr_buf[1]} == TALKER_NAMES[k]) code = 3'(k);
      return code;
   endfunction

   function automatic logic [3:0] sentence_of();
      logic [3:0] code;
      code = nsc_pkg::SENT_UNKNOWN;
      if (addr_len >= nsc_pkg::ADDR_MAX)
         for (int k = 1; k <= 10; k++)
            if ({addr_buf[2], addr_buf[3], addr_buf[4]} == SENT_NAMES[k]) code = 4'(k);
      return code;
   endfunction

   function automatic nsc_pkg::result_type verdict(input logic [2:0] code,
                                                   input logic [2:0] talker,
                                                   input logic [3:0] sent,
                                                   input logic [7:0] x);
      nsc_pkg::result_type r;
      r.sentence_ok   = (code == nsc_pkg::ERR_NONE);
      r.error_code    = code;
      r.talker_code   = talker;
      r.sentence_code = sent;
      r.computed_xor  = x;
      return r;
   endfunction

   // Latch the first error only; the fault phase swallows everything after it.
   task automatic flag_error(input logic [2:0] code);
      err = code;
      ph = nsc_pkg::PH_FAULT;
   endtask

   // Advance the parser by one accepted word; on tlast, hand back the verdict.
   task automatic parse_char(input logic [7:0] c, input bit last,
                             output bit produced, output nsc_pkg::result_type v);
      logic [4:0] nib;
      produced = 1'b0;
      v = '0;
      // Address field: up to five characters after the first, ending at ',' or '*'.
      if (ph != nsc_pkg::PH_DOLLAR && !addr_closed) begin
         if (c == nsc_pkg::CH_COMMA || c == nsc_pkg::CH_STAR) begin
            addr_closed = 1'b1;
         end else if (addr_len < nsc_pkg::ADDR_MAX) begin
            addr_buf[addr_len] = c;
            addr_len++;
         end
      end
      case (ph)
         nsc_pkg::PH_DOLLAR: begin
            if (c == nsc_pkg::CH_DOLLAR) ph = nsc_pkg::PH_BODY;
            else flag_error(nsc_pkg::ERR_DOLLAR);
         end
         nsc_pkg::PH_BODY: begin
            if (c == nsc_pkg::CH_STAR) ph = nsc_pkg::PH_HEX1; else xor_acc ^= c;
         end
         nsc_pkg::PH_HEX1: begin
            nib = hex_nibble(c);
            if (nib[4]) begin
               flag_error(nsc_pkg::ERR_HEX);
            end else begin
               hi_nib = nib[3:0];
               ph = nsc_pkg::PH_HEX2;
            end
         end
         nsc_pkg::PH_HEX2: begin
            nib = hex_nibble(c);
            if (nib[4]) flag_error(nsc_pkg::ERR_HEX);
            else if ({hi_nib, nib[3:0]} != xor_acc) flag_error(nsc_pkg::ERR_CHECKSUM);
            else ph = nsc_pkg::PH_CR;
         end
         nsc_pkg::PH_CR: begin
            if (c == nsc_pkg::CH_CR) ph = nsc_pkg::PH_LF;
            else flag_error(nsc_pkg::ERR_ENDING);
         end
         nsc_pkg::PH_LF: begin
            if (c == nsc_pkg::CH_LF) ph = nsc_pkg::PH_DONE;
            else flag_error(nsc_pkg::ERR_ENDING);
         end
         nsc_pkg::PH_DONE: flag_error(nsc_pkg::ERR_ENDING);
         default: ;
      endcase
      if (last) begin
         // Sentence cut short: name the piece that is missing.
         if (err == nsc_pkg::ERR_NONE) begin
            case (ph)
               nsc_pkg::PH_BODY:                   err = nsc_pkg::ERR_STAR;
               nsc_pkg::PH_HEX1, nsc_pkg::PH_HEX2: err = nsc_pkg::ERR_HEX;
               nsc_pkg::PH_CR, nsc_pkg::PH_LF:     err = nsc_pkg::ERR_ENDING;
               default: ;
            endcase
         end
         v = verdict(err, talker_of(), sentence_of(), xor_acc);
         produced = 1'b1;
         clear_checker();
      end
   endtask

   // ------------------------------------------------------------ stimulus

   // Mostly a random idle gap, with occasional runs of back-to-back words.
   task automatic draw_wait(inout int run_left, output int n);
      if (run_left > 0) begin
         run_left--;
         n = 0;
      end else if ($urandom_range(0, 15) == 0) begin
         run_left = $urandom_range(10, 40);
         n = 0;
      end else begin
         n = $urandom_range(0, 6);
      end
   endtask

   task automatic send_and_predict(input logic [7:0] c, input bit last, input bit typed,
                                   input nsc_pkg::result_type want);
      int                  gap;
      bit                  produced;
      nsc_pkg::result_type predicted;
      draw_wait(source_run, gap);
      if (gap > 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= c;
      req_tlast  <= last;
      do @(posedge clock); while (!req_tready);
      parse_char(c, last, produced, predicted);
      if (produced) expected_verdicts.push_back(typed ? want : predicted);
   endtask

   // Hold off the sender until every verdict in flight has been read back.
   task automatic drain_pause();
      req_tvalid <= 1'b0;
      @(posedge clock);
      while (expected_verdicts.size() != 0) @(posedge clock);
   endtask

   task automatic add_row(input logic [7:0] c, input bit last, input bit typed,
                          input nsc_pkg::result_type want);
      stim_row_type row;
      row.ch = c;
      row.last = last;
      row.typed = typed;
      row.want = want;
      directed_rows.push_back(row);
   endtask

   task automatic add_text(input string s);
      for (int i = 0; i < s.len(); i++) add_row(s[i], 1'b0, 1'b0, '0);
   endtask

   function automatic logic [7:0] rand_upper();
      return 8'($urandom_range(CH_UPPER_A, CH_UPPER_Z));
   endfunction

   function automatic logic [7:0] hex_char(input logic [3:0] nib);
      return (nib < 4'd10) ? 8'(CH_ZERO + nib) : 8'(CH_UPPER_A + nib - 8'd10);
   endfunction

   // Fill sentence_buf with one sentence: a well-formed frame with random content
   // most of the time, with broken checksums, bad digits, cut-offs and junk mixed in.
   task automatic build_sentence();
      logic [39:0] addr;
      logic [15:0] pair;
      logic [23:0] trio;
      logic [7:0]  ck, ck_sent, hi_c, lo_c, c;
      int          pick, n, len;
      sentence_buf.delete();
      pick = $urandom_range(0, 99);
      if (pick < 5) begin
         // raw noise; may still start with a dollar by chance
         n = $urandom_range(1, 6);
         repeat (n) sentence_buf.push_back(8'($urandom_range(0, 255)));
         return;
      end
      sentence_buf.push_back(nsc_pkg::CH_DOLLAR);
      if (pick < 85) begin
         n = $urandom_range(0, 7);
         pair = (n < 6) ? TALKER_NAMES[n + 1] : {rand_upper(), rand_upper()};
         n = $urandom_range(0, 12);
         trio = (n < 10) ? SENT_NAMES[n + 1] : {rand_upper(), rand_upper(), rand_upper()};
         addr = {pair, trio};
         n = $urandom_range(0, 9);
         len = (n == 0) ? $urandom_range(0, 4) : 5;
         for (int i = 0; i < len; i++) sentence_buf.push_back(addr[39 - 8*i -: 8]);
         if (n == 1) repeat ($urandom_range(1, 3)) sentence_buf.push_back(rand_upper());
         repeat ($urandom_range(0, 3)) begin
            sentence_buf.push_back(nsc_pkg::CH_COMMA);
            repeat ($urandom_range(0, 5)) begin
               do c = 8'($urandom_range(CH_SPACE, CH_TILDE)); while (c == nsc_pkg::CH_STAR);
               sentence_buf.push_back(c);
            end
         end
      end else begin
         repeat ($urandom_range(0, 8)) begin
            do c = 8'($urandom_range(0, 255)); while (c == nsc_pkg::CH_STAR);
            sentence_buf.push_back(c);
         end
      end
      ck = '0;
      for (int i = 1; i < sentence_buf.size(); i++) ck ^= sentence_buf[i];
      sentence_buf.push_back(nsc_pkg::CH_STAR);
      pick = $urandom_range(0, 19);
      ck_sent = (pick < 2) ? ck ^ 8'($urandom_range(1, 255)) : ck;
      hi_c = hex_char(ck_sent[7:4]);
      lo_c = hex_char(ck_sent[3:0]);
      if (pick == 2) begin
         if ($urandom_range(0, 1)) hi_c = 8'(CH_LOWER_A + $urandom_range(0, 5));
         else lo_c = 8'(CH_LOWER_A + $urandom_range(0, 5));
      end else if (pick == 3) begin
         lo_c = 8'($urandom_range(8'h47, CH_UPPER_Z));
      end
      sentence_buf.push_back(hi_c);
      sentence_buf.push_back(lo_c);
      sentence_buf.push_back(nsc_pkg::CH_CR);
      sentence_buf.push_back(nsc_pkg::CH_LF);
      pick = $urandom_range(0, 99);
      if (pick < 8) begin
         do c = 8'($urandom_range(0, 255)); while (c == nsc_pkg::CH_DOLLAR);
         sentence_buf[0] = c;
      end else if (pick < 18) begin
         n = $urandom_range(1, sentence_buf.size() - 1);
         sentence_buf = sentence_buf[0:n-1];
      end else if (pick < 23) begin
         repeat ($urandom_range(1, 2)) sentence_buf.push_back(8'($urandom_range(0, 255)));
      end else if (pick < 28) begin
         sentence_buf[sentence_buf.size() - $urandom_range(1, 2)] = 8'($urandom_range(0, 255));
      end
   endtask

   // ----------------------------------------------------------- checking

   task automatic check_field(input string name, input logic [7:0] want, input logic [7:0] got);
      if (want !== got) begin
         $display("%0t: %s mismatch, expected %0h, got %0h", $time, name, want, got);
         mismatch_count++;
      end
   endtask

   initial begin : result_sink
      int                  stall;
      nsc_pkg::result_type want;
      while (reset) @(posedge clock);
      forever begin
         draw_wait(sink_run, stall);
         if (stall > 0) begin
            rsp_tready <= 1'b0;
            repeat (stall) @(posedge clock);
         end
         rsp_tready <= 1'b1;
         do @(posedge clock); while (!rsp_tvalid);
         if (expected_verdicts.size() == 0) begin
            $display("%0t: unexpected result word, expected none, got tdata=%h tuser=%b",
                     $time, rsp_tdata, rsp_tuser);
            mismatch_count++;
         end else begin
            want = expected_verdicts.pop_front();
            check_field("sentence_ok", 8'(want.sentence_ok), 8'(rsp_tuser[0]));
            check_field("error_code", 8'(want.error_code), 8'(rsp_tdata[2:0]));
            check_field("talker_code", 8'(want.talker_code), 8'(rsp_tdata[5:3]));
            check_field("sentence_code", 8'(want.sentence_code), 8'(rsp_tdata[9:6]));
            check_field("computed_xor", want.computed_xor, rsp_tdata[17:10]);
         end
      end
   end

   // --------------------------------------------------------------- main

   initial begin : word_source
      int words_sent;
      int sentences_sent;
      clear_checker();

      // Directed table: verdicts typed in where they are obvious.
      add_row("A", 1'b1, 1'b1, verdict(nsc_pkg::ERR_DOLLAR, nsc_pkg::TALKER_UNKNOWN,
                                       nsc_pkg::SENT_UNKNOWN, 8'h00));
      add_row(nsc_pkg::CH_DOLLAR, 1'b1, 1'b1, verdict(nsc_pkg::ERR_STAR,
              nsc_pkg::TALKER_UNKNOWN, nsc_pkg::SENT_UNKNOWN, 8'h00));
      add_row(nsc_pkg::CH_DOLLAR, 1'b0, 1'b0, '0);
      add_row(nsc_pkg::CH_STAR, 1'b1, 1'b1, verdict(nsc_pkg::ERR_HEX,
              nsc_pkg::TALKER_UNKNOWN, nsc_pkg::SENT_UNKNOWN, 8'h00));
      add_text("$GPGGA*56");
      add_row(nsc_pkg::CH_CR, 1'b0, 1'b0, '0);
      add_row(nsc_pkg::CH_LF, 1'b1, 1'b0, '0);
      // extreme bytes in the body, then a lower-case digit
      add_row(nsc_pkg::CH_DOLLAR, 1'b0, 1'b0, '0);
      add_row(8'hFF, 1'b0, 1'b0, '0);
      add_row(8'h00, 1'b0, 1'b0, '0);
      add_text("*0");
      add_row("a", 1'b1, 1'b1, verdict(nsc_pkg::ERR_HEX, nsc_pkg::TALKER_UNKNOWN,
                                       nsc_pkg::SENT_UNKNOWN, 8'hFF));
      // a good empty sentence spoiled by a character after LF
      add_text("$*00");
      add_row(nsc_pkg::CH_CR, 1'b0, 1'b0, '0);
      add_row(nsc_pkg::CH_LF, 1'b0, 1'b0, '0);
      add_row(nsc_pkg::CH_LF, 1'b1, 1'b1, verdict(nsc_pkg::ERR_ENDING,
              nsc_pkg::TALKER_UNKNOWN, nsc_pkg::SENT_UNKNOWN, 8'h00));

      repeat (2) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      foreach (directed_rows[i])
         send_and_predict(directed_rows[i].ch, directed_rows[i].last, directed_rows[i].typed,
                          directed_rows[i].want);
      drain_pause();

      words_sent = 0;
      sentences_sent = 0;
      while (words_sent < RANDOM_WORDS || sentences_sent < RANDOM_SENTENCES) begin
         if ($urandom_range(0, 11) == 0) drain_pause();
         build_sentence();
         foreach (sentence_buf[i])
            send_and_predict(sentence_buf[i], i == sentence_buf.size() - 1, 1'b0, '0);
         words_sent += sentence_buf.size();
         sentences_sent++;
      end
      req_tvalid <= 1'b0;

      // Drain, then give any stray word time to show up.
      while (expected_verdicts.size() != 0) @(posedge clock);
      repeat (8) @(posedge clock);
      if (mismatch_count == 0)
         $display("nmea_sentence_checker_unit_test: done, clean");
      else
         $display("nmea_sentence_checker_unit_test: done, errors");
      $finish;
   end

endmodule
